/* design/bcp_pkg.sv */
// Shared types and constants for the bandwidth credit pacer.
`default_nettype none
package bcp_pkg;

   localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NS_PER_US     = 64'd1000;
   localparam logic [63:0] BYTE_NS_DENOM = 64'd8000000000;
   localparam logic [63:0] SEND_CLAMP    = 64'h0000_0000_8000_0000;

   localparam logic [1:0] KIND_QUERY = 2'd0;
   localparam logic [1:0] KIND_SEND  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic CSR_RATE   = 1'b0;
   localparam logic CSR_WINDOW = 1'b1;

   typedef struct packed {
      logic        start;
      logic        op_div;
      logic [63:0] a;
      logic [63:0] b;
   } arith_ctl_type;

endpackage
`default_nettype wire

/* design/bcp_arith.sv */
// Shared bit-serial unit: 64x64 shift-add multiply or 64/64 restoring divide.
`default_nettype none
module bcp_arith (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bcp_pkg::arith_ctl_type ctl,
   output logic                        busy,
   output logic [63:0]                 res_hi,
   output logic [63:0]                 res_lo
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        div_ff, div_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] hi_ff, hi_in;
   logic [63:0] lo_ff, lo_in;

   logic [64:0] mul_sum;
   logic [64:0] div_sh;
   logic [64:0] div_dif;

   always_comb begin
      mul_sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : 65'd0);
      div_sh  = {hi_ff, lo_ff[63]};
      div_dif = div_sh - {1'b0, b_ff};

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;

      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = ctl.op_div;
         a_in    = ctl.a;
         b_in    = ctl.b;
         hi_in   = '0;
         lo_in   = ctl.op_div ? ctl.a : ctl.b;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
         end
         if (div_ff) begin
            if (div_sh >= {1'b0, b_ff}) begin
               hi_in = div_dif[63:0];
               lo_in = {lo_ff[62:0], 1'b1};
            end else begin
               hi_in = div_sh[63:0];
               lo_in = {lo_ff[62:0], 1'b0};
            end
         end else begin
            hi_in = mul_sum[64:1];
            lo_in = {mul_sum[0], lo_ff[63:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign busy   = busy_ff;
   assign res_hi = hi_ff;
   assign res_lo = lo_ff;

endmodule
`default_nettype wire

/* design/bandwidth_credit_pacer_unit.sv */
// Top level of the bandwidth credit pacer: sequencer, state and handshakes.
// Each multiply or divide runs on one shared bit-serial unit; the sequencer waits until the
// unit is no longer busy and then resumes. A request takes one unit operation per step: up to 9
// steps for a query in normal mode; unlimited-rate queries go straight to the response without
// using the unit; clear requests only reset the credit base.
// One request is in flight at a time; the next is taken once the last one is done and any response delivered.
// Synchronous reset clears the credit base and both configuration registers.
`default_nettype none
module bandwidth_credit_pacer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [63:0] req_size_bytes,
   input  wire logic [54:0] req_now_usec,
   input  wire logic [15:0] req_mtu,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_allowed_bytes,
   output logic [54:0]      rsp_delay_usec,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_write_data
);

   typedef enum logic [18:0] {
      S_IDLE  = 19'h00001,
      S_WAIT  = 19'h00002,
      S_NOW   = 19'h00004,
      S_WIN   = 19'h00008,
      S_BUD   = 19'h00010,
      S_STR   = 19'h00020,
      S_PATH  = 19'h00040,
      S_MD1   = 19'h00080,
      S_MD2   = 19'h00100,
      S_D1    = 19'h00200,
      S_D2    = 19'h00400,
      S_AL1   = 19'h00800,
      S_AL2   = 19'h01000,
      S_NEED  = 19'h02000,
      S_NEED1 = 19'h04000,
      S_NEED2 = 19'h08000,
      S_EARL  = 19'h10000,
      S_CEIL  = 19'h20000,
      S_OUT   = 19'h40000
   } state_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? bcp_pkg::ALL_ONES : s[63:0];
   endfunction

   function automatic logic [63:0] max64(input logic [63:0] a, input logic [63:0] b);
      return (a > b) ? a : b;
   endfunction

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   logic [63:0] rate_ff, rate_in;
   logic [63:0] window_ff, window_in;
   logic [63:0] base_ff, base_in;
   logic [1:0]  kind_ff, kind_in;
   logic [63:0] size_ff, size_in;
   logic [15:0] mtu_ff, mtu_in;
   logic [63:0] now_ns_ff, now_ns_in;
   logic [63:0] wns_ff, wns_in;
   logic        strict_ff, strict_in;
   logic [63:0] md_ff, md_in;
   logic [63:0] eff_ff, eff_in;
   logic [63:0] need_ff, need_in;
   logic [63:0] allowed_ff, allowed_in;
   logic [54:0] delay_ff, delay_in;

   bcp_pkg::arith_ctl_type arith_ctl;
   logic        arith_busy;
   logic [63:0] res_hi;
   logic [63:0] res_lo;

   logic [63:0] prod_val;
   logic [63:0] size_cl;
   logic [63:0] wfloor;
   logic [63:0] eff_q;
   logic [63:0] earl;
   logic [63:0] strict_floor;
   logic [63:0] dly_sum;

   bcp_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (arith_ctl),
      .busy   (arith_busy),
      .res_hi (res_hi),
      .res_lo (res_lo)
   );

   always_comb begin
      prod_val     = (res_hi != 64'd0) ? bcp_pkg::ALL_ONES : res_lo;
      size_cl      = (size_ff > bcp_pkg::SEND_CLAMP) ? bcp_pkg::SEND_CLAMP : size_ff;
      wfloor       = (now_ns_ff >= wns_ff) ? now_ns_ff - wns_ff : 64'd0;
      eff_q        = (window_ff == 64'd0) ? base_ff : max64(base_ff, wfloor);
      earl         = sat_add(eff_ff, need_ff);
      strict_floor = (now_ns_ff >= md_ff) ? now_ns_ff - md_ff : 64'd0;
      dly_sum      = res_lo + {63'd0, (res_hi != 64'd0)};

      state_in   = state_ff;
      ret_in     = ret_ff;
      rate_in    = rate_ff;
      window_in  = window_ff;
      base_in    = base_ff;
      kind_in    = kind_ff;
      size_in    = size_ff;
      mtu_in     = mtu_ff;
      now_ns_in  = now_ns_ff;
      wns_in     = wns_ff;
      strict_in  = strict_ff;
      md_in      = md_ff;
      eff_in     = eff_ff;
      need_in    = need_ff;
      allowed_in = allowed_ff;
      delay_in   = delay_ff;
      arith_ctl  = '0;

      if (csr_write_enable) begin
         unique case (csr_index)
            bcp_pkg::CSR_RATE:   rate_in   = csr_write_data;
            bcp_pkg::CSR_WINDOW: window_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               size_in   = req_size_bytes;
               mtu_in    = req_mtu;
               case (req_kind)
                  bcp_pkg::KIND_QUERY: begin
                     if (rate_ff == 64'd0) begin
                        allowed_in = bcp_pkg::ALL_ONES;
                        delay_in   = '0;
                        state_in   = S_OUT;
                     end else begin
                        arith_ctl = '{1'b1, 1'b0, {9'd0, req_now_usec}, bcp_pkg::NS_PER_US};
                        ret_in    = S_NOW;
                        state_in  = S_WAIT;
                     end
                  end
                  bcp_pkg::KIND_SEND: begin
                     if (rate_ff != 64'd0 && req_size_bytes != 64'd0) begin
                        arith_ctl = '{1'b1, 1'b0, {9'd0, req_now_usec}, bcp_pkg::NS_PER_US};
                        ret_in    = S_NOW;
                        state_in  = S_WAIT;
                     end
                  end
                  bcp_pkg::KIND_CLEAR: base_in = '0;
                  default: ;
               endcase
            end
         end
         S_WAIT: begin
            if (!arith_busy) begin
               state_in = ret_ff;
            end
         end
         S_NOW: begin
            now_ns_in = prod_val;
            arith_ctl = '{1'b1, 1'b0, window_ff, bcp_pkg::NS_PER_US};
            ret_in    = S_WIN;
            state_in  = S_WAIT;
         end
         S_WIN: begin
            wns_in = prod_val;
            if (mtu_ff != 16'd0) begin
               arith_ctl = '{1'b1, 1'b0, prod_val, rate_ff};
               ret_in    = S_BUD;
               state_in  = S_WAIT;
            end else begin
               strict_in = 1'b0;
               state_in  = S_PATH;
            end
         end
         S_BUD: begin
            arith_ctl = '{1'b1, 1'b1, prod_val, bcp_pkg::BYTE_NS_DENOM};
            ret_in    = S_STR;
            state_in  = S_WAIT;
         end
         S_STR: begin
            strict_in = res_lo < {48'd0, mtu_ff};
            state_in  = S_PATH;
         end
         S_PATH: begin
            state_in = S_WAIT;
            if (strict_ff) begin
               arith_ctl = '{1'b1, 1'b0, {48'd0, mtu_ff}, bcp_pkg::BYTE_NS_DENOM};
               ret_in    = S_MD1;
            end else if (kind_ff == bcp_pkg::KIND_SEND) begin
               arith_ctl = '{1'b1, 1'b0, size_cl, bcp_pkg::BYTE_NS_DENOM};
               ret_in    = S_D1;
            end else begin
               eff_in    = eff_q;
               arith_ctl = '{1'b1, 1'b0,
                             (now_ns_ff > eff_q) ? now_ns_ff - eff_q : 64'd0, rate_ff};
               ret_in    = S_AL1;
            end
         end
         S_MD1: begin
            arith_ctl = '{1'b1, 1'b1, res_lo, rate_ff};
            ret_in    = S_MD2;
            state_in  = S_WAIT;
         end
         S_MD2: begin
            md_in = res_lo;
            if (kind_ff == bcp_pkg::KIND_SEND) begin
               arith_ctl = '{1'b1, 1'b0, size_cl, bcp_pkg::BYTE_NS_DENOM};
               ret_in    = S_D1;
               state_in  = S_WAIT;
            end else if (now_ns_ff >= base_ff && (now_ns_ff - base_ff) >= res_lo) begin
               allowed_in = {48'd0, mtu_ff};
               delay_in   = '0;
               state_in   = S_OUT;
            end else begin
               allowed_in = '0;
               delay_in   = '0;
               eff_in     = base_ff;
               need_in    = res_lo;
               state_in   = (size_ff == 64'd0) ? S_OUT : S_EARL;
            end
         end
         S_D1: begin
            arith_ctl = '{1'b1, 1'b1, res_lo, rate_ff};
            ret_in    = S_D2;
            state_in  = S_WAIT;
         end
         S_D2: begin
            if (strict_ff) begin
               base_in = sat_add(max64(base_ff, strict_floor), max64(res_lo, md_ff));
            end else if (window_ff == 64'd0) begin
               base_in = sat_add(max64(base_ff, now_ns_ff), res_lo);
            end else begin
               base_in = sat_add(max64(base_ff, wfloor), res_lo);
            end
            state_in = S_IDLE;
         end
         S_AL1: begin
            if (res_hi != 64'd0) begin
               allowed_in = bcp_pkg::ALL_ONES;
               state_in   = S_NEED;
            end else begin
               arith_ctl = '{1'b1, 1'b1, res_lo, bcp_pkg::BYTE_NS_DENOM};
               ret_in    = S_AL2;
               state_in  = S_WAIT;
            end
         end
         S_AL2: begin
            allowed_in = res_lo;
            state_in   = S_NEED;
         end
         S_NEED: begin
            if (size_ff == 64'd0) begin
               delay_in = '0;
               state_in = S_OUT;
            end else begin
               arith_ctl = '{1'b1, 1'b0, size_ff, bcp_pkg::BYTE_NS_DENOM};
               ret_in    = S_NEED1;
               state_in  = S_WAIT;
            end
         end
         S_NEED1: begin
            if (res_hi != 64'd0) begin
               need_in  = bcp_pkg::ALL_ONES;
               state_in = S_EARL;
            end else begin
               arith_ctl = '{1'b1, 1'b1, res_lo, rate_ff};
               ret_in    = S_NEED2;
               state_in  = S_WAIT;
            end
         end
         S_NEED2: begin
            need_in  = res_lo;
            state_in = S_EARL;
         end
         S_EARL: begin
            if (earl > now_ns_ff) begin
               arith_ctl = '{1'b1, 1'b1, earl - now_ns_ff, bcp_pkg::NS_PER_US};
               ret_in    = S_CEIL;
               state_in  = S_WAIT;
            end else begin
               delay_in = '0;
               state_in = S_OUT;
            end
         end
         S_CEIL: begin
            delay_in = dly_sum[54:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         rate_ff   <= '0;
         window_ff <= '0;
         base_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         rate_ff   <= rate_in;
         window_ff <= window_in;
         base_ff   <= base_in;
      end
      kind_ff    <= kind_in;
      size_ff    <= size_in;
      mtu_ff     <= mtu_in;
      now_ns_ff  <= now_ns_in;
      wns_ff     <= wns_in;
      strict_ff  <= strict_in;
      md_ff      <= md_in;
      eff_ff     <= eff_in;
      need_ff    <= need_in;
      allowed_ff <= allowed_in;
      delay_ff   <= delay_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = (state_ff == S_OUT);
   assign rsp_allowed_bytes = allowed_ff;
   assign rsp_delay_usec    = delay_ff;

   // the unit is never restarted while an operation is in progress
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      arith_ctl.start |-> !arith_busy)
      else $error("arith unit restarted while busy");

   a_wait_return: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && !arith_busy) |=> (state_ff == $past(ret_ff)))
      else $error("sequencer did not resume after unit finished");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("request taken while a response is pending");

endmodule
`default_nettype wire
